FILE: src/tkf_pkg.sv
`default_nettype none
package tkf_pkg;

  // field widths fixed by the item format
  localparam int unsigned FieldW = 31;
  localparam int unsigned KeyW   = 2 * FieldW;
  localparam int unsigned CfgW   = 5;

  // reset value of the keep count register
  localparam logic [CfgW-1:0] KeepReset = CfgW'(16);

  // command codes
  localparam logic CmdAdd    = 1'b0;
  localparam logic CmdFinish = 1'b1;

  // sequencer states
  typedef enum logic {
    StIdle,
    StDrain
  } state_e;

  // what one cell hands to its neighbours
  typedef struct packed {
    logic            valid;
    logic            stay;
    logic [KeyW-1:0] key;
  } link_t;

  // per-cycle operation for the whole row
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/tkf_cell.sv
`default_nettype none
module tkf_cell
  import tkf_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire logic            limit_i,
  input  wire logic [KeyW-1:0] new_key_i,
  input  wire link_t           prev_i,
  input  wire link_t           next_i,
  output link_t                link_o
);

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic            stay;

  // entry ranks at least as high as the new pair, so it keeps its place
  assign stay = valid_q && (key_q >= new_key_i);

  assign link_o.valid = valid_q;
  assign link_o.stay  = stay;
  assign link_o.key   = key_q;

  // insert: hold, take the new pair, or take the neighbour above
  // shift: move up one place towards the head during readout
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      key_d   = next_i.key;
    end else if (ctrl_i.insert) begin
      valid_d = limit_i && (valid_q || prev_i.valid);
      if (!stay) begin
        if (prev_i.stay) begin
          key_d = new_key_i;
        end else begin
          key_d = prev_i.key;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
`default_nettype wire

FILE: src/top_k_by_term_frequency_unit.sv
`default_nettype none
// Keeps the best k (term frequency, document id) pairs of a set in a row of K_MAX sorted
// cells, best first, ranked by frequency and then by document id. An add item is taken
// every cycle and inserted in that cycle: each cell compares its entry with the new pair
// and holds, takes the pair, or takes its upper neighbour's entry. A finish item reads the
// row out through an output register, one ranked entry per cycle while the consumer takes
// them, shifting the row towards its head; an empty set gives a single result with
// has_entry 0, and no item is accepted until the final result has been loaded.
// keep_count 0 acts as 1, values above K_MAX as K_MAX.
module top_k_by_term_frequency_unit
  import tkf_pkg::*;
#(
  parameter int unsigned K_MAX = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgW-1:0]   cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              cmd_i,
  input  wire logic [FieldW-1:0] doc_id_i,
  input  wire logic [FieldW-1:0] term_freq_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [FieldW-1:0]      doc_id_res_o,
  output logic [FieldW-1:0]      term_freq_res_o,
  output logic                   has_entry_o,
  output logic                   last_o
);

  state_e              state_q, state_d;
  logic [CfgW-1:0]     keep_q;
  logic                out_valid_q, out_valid_d;
  logic [KeyW-1:0]     out_key_q, out_key_d;
  logic                out_has_q, out_has_d;
  logic                out_last_q, out_last_d;
  logic                in_acc;
  logic                out_free;
  logic [KeyW-1:0]     new_key;
  cell_ctrl_t          ctrl;
  link_t               links [K_MAX];
  link_t               prevs [K_MAX];
  link_t               nexts [K_MAX];
  logic [K_MAX-1:0]    limit;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign new_key    = {term_freq_i, doc_id_i};

  // keep count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KeepReset;
    end else if (cfg_we_i) begin
      keep_q <= cfg_data_i;
    end
  end

  // row of cells with neighbour wiring
  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    localparam int unsigned Idx = g;

    assign limit[g] = (keep_q == '0) ? (Idx == 0) : (32'(keep_q) > Idx);

    if (g == 0) begin : g_head
      assign prevs[g] = '{valid: 1'b1, stay: 1'b1, key: '0};
    end else begin : g_body
      assign prevs[g] = links[g-1];
    end

    if (g == K_MAX - 1) begin : g_tail
      assign nexts[g] = '{valid: 1'b0, stay: 1'b0, key: '0};
    end else begin : g_inner
      assign nexts[g] = links[g+1];
    end

    tkf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .limit_i   (limit[g]),
      .new_key_i (new_key),
      .prev_i    (prevs[g]),
      .next_i    (nexts[g]),
      .link_o    (links[g])
    );
  end

  // sequencer: inserts in idle, readout from the head of the row in drain
  always_comb begin
    state_d     = state_q;
    ctrl        = '{insert: 1'b0, shift: 1'b0};
    out_valid_d = out_valid_q && !out_ready_i;
    out_key_d   = out_key_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (cmd_i == CmdFinish) begin
            state_d = StDrain;
          end else begin
            ctrl.insert = 1'b1;
          end
        end
      end
      StDrain: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_has_d   = links[0].valid;
          out_key_d   = links[0].valid ? links[0].key : '0;
          out_last_d  = !nexts[0].valid;
          ctrl.shift  = 1'b1;
          if (!nexts[0].valid) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_key_q  <= out_key_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign doc_id_res_o    = out_key_q[FieldW-1:0];
  assign term_freq_res_o = out_key_q[KeyW-1:FieldW];
  assign has_entry_o     = out_has_q;
  assign last_o          = out_last_q;

endmodule
`default_nettype wire

FILE: src/tkf_checker.sv
`default_nettype none
module tkf_checker
  import tkf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_o,
  input  wire logic              cmd_i,
  input  wire logic              out_valid_o,
  input  wire logic              out_ready_i,
  input  wire logic [FieldW-1:0] doc_id_res_o,
  input  wire logic [FieldW-1:0] term_freq_res_o,
  input  wire logic              has_entry_o,
  input  wire logic              last_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(doc_id_res_o)
      && $stable(term_freq_res_o) && $stable(has_entry_o) && $stable(last_o))
    else $error("result changed while stalled");

  // an empty-set result is the whole ranking
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_entry_o |-> last_o)
    else $error("empty result not marked last");

  // no item is taken while a ranking is still being read out
  a_drain_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("item accepted during readout");

  // a finish starts a readout
  a_finish_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CmdFinish) |=> !in_ready_o)
    else $error("finish did not start readout");

endmodule

bind top_k_by_term_frequency_unit tkf_checker u_tkf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .cmd_i           (cmd_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .doc_id_res_o    (doc_id_res_o),
  .term_freq_res_o (term_freq_res_o),
  .has_entry_o     (has_entry_o),
  .last_o          (last_o)
);
`default_nettype wire

FILE: verif/tb_top_k_by_term_frequency_unit.sv
`default_nettype none
module tb_top_k_by_term_frequency_unit;
  import tkf_pkg::*;

  localparam int KeepMax = 16;

  typedef struct packed {
    logic              cmd;
    logic [FieldW-1:0] doc;
    logic [FieldW-1:0] freq;
  } posting_t;

  typedef struct packed {
    logic [FieldW-1:0] doc;
    logic [FieldW-1:0] freq;
    logic              has;
    logic              fin;
  } ranked_t;

  logic              clk_i;
  logic              rst_n         = 1'b0;
  logic              cfg_we        = 1'b0;
  logic [CfgW-1:0]   cfg_data      = '0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic              cmd           = CmdAdd;
  logic [FieldW-1:0] doc_id        = '0;
  logic [FieldW-1:0] term_freq     = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [FieldW-1:0] doc_id_res;
  logic [FieldW-1:0] term_freq_res;
  logic              has_entry;
  logic              res_last;

  // postings waiting to be offered, and ranked entries still due
  posting_t posting_q[$];
  ranked_t  ranked_due_q[$];

  // predictor state: sorted keys, best first
  logic [KeyW-1:0] kept_key[KeepMax];
  int              kept_n   = 0;
  logic [CfgW-1:0] keep_reg = KeepReset;

  int fail_count  = 0;
  int pushed_n    = 0;
  int accepted_n  = 0;
  int idle_pct    = 15;
  int hold_left   = 0;
  logic hold_done = 1'b0;

  top_k_by_term_frequency_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (cmd),
    .doc_id_i        (doc_id),
    .term_freq_i     (term_freq),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .doc_id_res_o    (doc_id_res),
    .term_freq_res_o (term_freq_res),
    .has_entry_o     (has_entry),
    .last_o          (res_last)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // ranking predictor, applied to each accepted item
  function automatic void rank_item(input logic op, input logic [FieldW-1:0] doc,
                                    input logic [FieldW-1:0] freq);
    logic [KeyW-1:0] key;
    int eff;
    int pos;
    int n;
    key = {freq, doc};
    if (op == CmdAdd) begin
      eff = (keep_reg == 0) ? 1 : ((keep_reg > KeepMax) ? KeepMax : int'(keep_reg));
      pos = 0;
      while (pos < kept_n && kept_key[pos] >= key) pos++;
      if (pos >= eff) begin
        // ranks outside the window, but a lowered k still trims the store
        if (kept_n > eff) kept_n = eff;
        return;
      end
      n = (kept_n < KeepMax) ? kept_n : KeepMax - 1;
      for (int i = n; i > pos; i--) kept_key[i] = kept_key[i-1];
      kept_key[pos] = key;
      kept_n = n + 1;
      if (kept_n > eff) kept_n = eff;
    end else if (kept_n == 0) begin
      ranked_due_q.insert(ranked_due_q.size(), '{doc: '0, freq: '0, has: 1'b0, fin: 1'b1});
    end else begin
      for (int i = 0; i < kept_n; i++)
        ranked_due_q.insert(ranked_due_q.size(), '{doc: kept_key[i][FieldW-1:0],
                                                   freq: kept_key[i][KeyW-1:FieldW],
                                                   has: 1'b1, fin: (i == kept_n - 1)});
      kept_n = 0;
    end
  endfunction

  // driver: offers queued postings, holding each until accepted
  always @(posedge clk_i) begin
    posting_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rank_item(cmd, doc_id, term_freq);
        accepted_n++;
      end
      if (!in_valid || in_ready) begin
        if (posting_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = posting_q.pop_front();
          cmd       <= nxt.cmd;
          doc_id    <= nxt.doc;
          term_freq <= nxt.freq;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, one long hold in the no-idle stretch, field checks
  always @(posedge clk_i) begin
    ranked_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (ranked_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result doc %0d tf %0d has %0b last %0b",
                                    doc_id_res, term_freq_res, has_entry, res_last));
        end else begin
          want = ranked_due_q.pop_front();
          if (doc_id_res !== want.doc)
            report_mismatch($sformatf("doc_id_res %0d, expected %0d", doc_id_res, want.doc));
          if (term_freq_res !== want.freq)
            report_mismatch($sformatf("term_freq_res %0d, expected %0d",
                                      term_freq_res, want.freq));
          if (has_entry !== want.has)
            report_mismatch($sformatf("has_entry %0b, expected %0b", has_entry, want.has));
          if (res_last !== want.fin)
            report_mismatch($sformatf("last %0b, expected %0b", res_last, want.fin));
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (idle_pct == 0 && !hold_done && out_valid) begin
        hold_done <= 1'b1;
        hold_left <= 150;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  function automatic void push_item(input logic op, input logic [FieldW-1:0] doc,
                                    input logic [FieldW-1:0] freq);
    posting_q.insert(posting_q.size(), '{cmd: op, doc: doc, freq: freq});
    pushed_n++;
  endfunction

  // every item taken, every result seen, then a short settle
  task automatic wait_drained();
    while (accepted_n != pushed_n || ranked_due_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_keep_count(input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    keep_reg = value;
  endtask

  // mostly small values so that ties and repeated ids turn up
  function automatic logic [FieldW-1:0] pick_field();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return FieldW'($urandom_range(0, 7));
      default:    return FieldW'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    int n;
    int random_n;
    int phase;
    logic [CfgW-1:0] corner_k[6];
    corner_k = '{5'd0, 5'd1, 5'd31, 5'd16, 5'd17, 5'd2};

    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk_i);

    // empty set at reset k, then field extremes, ties and a repeated pair
    push_item(CmdFinish, '1, '1);
    push_item(CmdAdd, '0, '0);
    push_item(CmdAdd, '1, '1);
    push_item(CmdAdd, 31'd7, 31'd5);
    push_item(CmdAdd, 31'd9, 31'd5);
    push_item(CmdAdd, 31'd7, 31'd5);
    push_item(CmdAdd, 31'h2AAAAAAA, 31'h55555555);
    push_item(CmdFinish, '0, '0);
    wait_drained();

    // k lowered mid-set: finish still emits all held entries
    write_keep_count(5'd3);
    push_item(CmdAdd, 31'd1, 31'd10);
    push_item(CmdAdd, 31'd2, 31'd20);
    push_item(CmdAdd, 31'd3, 31'd30);
    wait_drained();
    write_keep_count(5'd1);
    push_item(CmdFinish, '0, '0);
    wait_drained();

    // k lowered mid-set: the next add, ranking last, trims the store
    write_keep_count(5'd3);
    push_item(CmdAdd, 31'd4, 31'd40);
    push_item(CmdAdd, 31'd5, 31'd50);
    push_item(CmdAdd, 31'd6, 31'd60);
    wait_drained();
    write_keep_count(5'd1);
    push_item(CmdAdd, 31'd7, 31'd1);
    push_item(CmdFinish, '0, '0);
    wait_drained();

    // random phases over several k settings
    random_n = 0;
    phase    = 0;
    while (random_n < 90) begin
      write_keep_count(phase < 6 ? corner_k[phase] : CfgW'($urandom_range(0, 31)));
      if (phase == 2) begin
        // no idling, full store, and a long output hold that backs up the input
        idle_pct = 0;
        for (int s = 0; s < 3; s++) begin
          n = (s == 0) ? 18 : 6;
          for (int i = 0; i < n; i++) push_item(CmdAdd, pick_field(), pick_field());
          push_item(CmdFinish, pick_field(), pick_field());
          random_n += n + 1;
        end
      end else begin
        n = $urandom_range(10, 20);
        for (int i = 0; i < n; i++) begin
          if (phase % 3 == 1 && i == n / 2) begin
            // change k with a set half built
            wait_drained();
            write_keep_count(CfgW'($urandom_range(0, 31)));
          end
          push_item($urandom_range(0, 6) == 0 ? CmdFinish : CmdAdd, pick_field(), pick_field());
        end
        push_item(CmdFinish, pick_field(), pick_field());
        random_n += n + 1;
      end
      wait_drained();
      if (phase == 3) idle_pct = 15;
      phase++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
